@@ sv/hvn_pkg.sv @@
package hvn_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] SALT_TAG  = 32'h9e3779b9;
    localparam logic [31:0] MIX_A     = 32'h2c1b3c6d;
    localparam logic [31:0] MIX_B     = 32'h297a2d39;
    localparam logic [15:0] INV_WL_RESET = 16'd3277;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // scaled position, 32 fraction bits
    typedef struct packed {
        logic signed [46:0] xs;
        logic signed [46:0] ys;
        logic [31:0]        salt;
    } q_item_t;

    typedef struct packed {
        logic afull;
        logic empty;
    } q_stat_t;

endpackage

@@ sv/hvn_front.sv @@
module hvn_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data,
    input  logic                   accept,
    input  logic signed [30:0]     x_pos,
    input  logic signed [30:0]     y_pos,
    input  logic [31:0]            salt,
    output logic                   push,
    output hvn_pkg::q_item_t       push_item
);
    import hvn_pkg::*;

    logic [15:0]       inv_reg;
    logic              vld_reg;
    q_item_t           item_reg;
    logic signed [47:0] prod_x;
    logic signed [47:0] prod_y;
    logic signed [16:0] inv_s;

    assign cfg_ready = 1'b1;
    assign inv_s  = $signed({1'b0, inv_reg});
    assign prod_x = 48'(x_pos) * 48'(inv_s);
    assign prod_y = 48'(y_pos) * 48'(inv_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= INV_WL_RESET;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                inv_reg <= cfg_data;
            end
            vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.xs   <= prod_x[46:0];
            item_reg.ys   <= prod_y[46:0];
            item_reg.salt <= salt;
        end
    end

    assign push      = vld_reg;
    assign push_item = item_reg;
endmodule

@@ sv/hvn_queue.sv @@
module hvn_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hvn_pkg::q_item_t  push_item,
    input  logic              pop,
    output hvn_pkg::q_item_t  head,
    output hvn_pkg::q_stat_t  stat
);
    import hvn_pkg::*;

    q_item_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_pop;

    assign do_pop = pop && (cnt_reg != '0);
    assign head   = mem_reg[rd_reg];
    // one slot is held back for the beat already in the front register
    assign stat.afull = cnt_reg >= QCNT_W'(QDEPTH - 1);
    assign stat.empty = cnt_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end
endmodule

@@ sv/hvn_back.sv @@
module hvn_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  hvn_pkg::q_item_t  in_item,
    output logic              done,
    output logic [15:0]       noise
);
    import hvn_pkg::*;

    localparam int F = FRACTION_BITS;
    localparam int NS = 12;
    localparam logic [F:0] ONE = (F+1)'(1) << F;
    localparam logic [F:0] HALF = (F+1)'(1) << (F - 1);

    typedef struct packed {
        logic signed [16:0]       kx0;
        logic signed [16:0]       kx1;
        logic signed [16:0]       ky0;
        logic signed [16:0]       ky1;
        logic [31:0]              salt;
        logic [F-1:0]             tx;
        logic [F-1:0]             ty;
        logic [2*F-1:0]           ttx;
        logic [2*F-1:0]           tty;
        logic [2*F+2:0]           srx;
        logic [2*F+2:0]           sry;
        logic [F:0]               sx;
        logic [F:0]               sy;
        logic [3:0][31:0]         h;
        logic [3:0][24:0]         val;
        logic [3:0][F+25:0]       p;
        logic [24:0]              top;
        logic [24:0]              bot;
    } bk_t;

    bk_t         st_reg  [1:NS];
    bk_t         st_next [1:NS];
    logic [NS:1] vld_reg;
    bk_t         s0;
    logic        done_reg;
    logic [15:0] noise_reg;
    logic [15:0] noise_next;

    function automatic logic signed [16:0] lane_x(input bk_t s, input int i);
        lane_x = ((i % 2) == 1) ? s.kx1 : s.kx0;
    endfunction

    function automatic logic signed [16:0] lane_y(input bk_t s, input int i);
        lane_y = (i >= 2) ? s.ky1 : s.ky0;
    endfunction

    function automatic logic [31:0] fnv(input logic [31:0] h, input logic [31:0] w);
        fnv = 32'((h ^ w) * FNV_PRIME);
    endfunction

    function automatic logic [2*F+2:0] fade_mul(input logic [2*F-1:0] tt,
                                               input logic [F-1:0] t);
        logic [F:0]   q;
        logic [F+1:0] m;
        q = (F+1)'(({1'b0, tt} + (2*F+1)'(HALF)) >> F);
        m = (F+2)'(3 * ONE) - (F+2)'({t, 1'b0});
        fade_mul = (2*F+3)'(q) * (2*F+3)'(m);
    endfunction

    function automatic logic [F:0] fade_cap(input logic [2*F+2:0] sr);
        logic [2*F+3:0] r;
        r = ({1'b0, sr} + (2*F+4)'(HALF)) >> F;
        fade_cap = (r > (2*F+4)'(ONE)) ? ONE : (F+1)'(r);
    endfunction

    always_comb
    begin
        logic [31:0] t;
        logic [F+26:0] sum;
        logic [24:0]   v;
        logic [24:0]   r;

        s0      = '0;
        s0.kx0  = {{2{in_item.xs[46]}}, in_item.xs[46:32]};
        s0.ky0  = {{2{in_item.ys[46]}}, in_item.ys[46:32]};
        s0.kx1  = s0.kx0 + 17'sd1;
        s0.ky1  = s0.ky0 + 17'sd1;
        s0.tx   = in_item.xs[31:32-F];
        s0.ty   = in_item.ys[31:32-F];
        s0.salt = in_item.salt;

        st_next[1] = s0;
        st_next[1].ttx = (2*F)'(s0.tx) * (2*F)'(s0.tx);
        st_next[1].tty = (2*F)'(s0.ty) * (2*F)'(s0.ty);
        for (int i = 0; i < 4; i++)
        begin
            st_next[1].h[i] = fnv(FNV_BASIS, 32'(lane_x(s0, i)));
        end

        st_next[2] = st_reg[1];
        st_next[2].srx = fade_mul(st_reg[1].ttx, st_reg[1].tx);
        st_next[2].sry = fade_mul(st_reg[1].tty, st_reg[1].ty);
        for (int i = 0; i < 4; i++)
        begin
            st_next[2].h[i] = fnv(st_reg[1].h[i], {32{lane_x(st_reg[1], i) < 17'sd0}});
        end

        st_next[3] = st_reg[2];
        st_next[3].sx = fade_cap(st_reg[2].srx);
        st_next[3].sy = fade_cap(st_reg[2].sry);
        for (int i = 0; i < 4; i++)
        begin
            st_next[3].h[i] = fnv(st_reg[2].h[i], 32'(lane_y(st_reg[2], i)));
        end

        st_next[4] = st_reg[3];
        st_next[5] = st_reg[4];
        st_next[6] = st_reg[5];
        st_next[7] = st_reg[6];
        st_next[8] = st_reg[7];
        st_next[9] = st_reg[8];
        for (int i = 0; i < 4; i++)
        begin
            st_next[4].h[i] = fnv(st_reg[3].h[i], {32{lane_y(st_reg[3], i) < 17'sd0}});
            st_next[5].h[i] = fnv(st_reg[4].h[i], st_reg[4].salt);
            st_next[6].h[i] = fnv(st_reg[5].h[i], SALT_TAG);
            t = st_reg[6].h[i] ^ (st_reg[6].h[i] >> 15);
            st_next[7].h[i] = 32'(t * MIX_A);
            t = st_reg[7].h[i] ^ (st_reg[7].h[i] >> 12);
            st_next[8].h[i] = 32'(t * MIX_B);
            t = st_reg[8].h[i] ^ (st_reg[8].h[i] >> 15);
            // rounds v*2^24/(2^24-1), so the full value reaches 1.0
            st_next[9].val[i] = {1'b0, t[23:0]} + 25'(t[23]);
        end

        st_next[10] = st_reg[9];
        for (int i = 0; i < 4; i++)
        begin
            st_next[10].p[i] = (F+26)'(st_reg[9].val[i])
                * (F+26)'(((i % 2) == 1) ? st_reg[9].sx : ONE - st_reg[9].sx);
        end

        st_next[11] = st_reg[10];
        sum = (F+27)'(st_reg[10].p[0]) + (F+27)'(st_reg[10].p[1]) + (F+27)'(HALF);
        st_next[11].top = 25'(sum >> F);
        sum = (F+27)'(st_reg[10].p[2]) + (F+27)'(st_reg[10].p[3]) + (F+27)'(HALF);
        st_next[11].bot = 25'(sum >> F);

        st_next[12] = st_reg[11];
        st_next[12].p[0] = (F+26)'(st_reg[11].top) * (F+26)'(ONE - st_reg[11].sy);
        st_next[12].p[1] = (F+26)'(st_reg[11].bot) * (F+26)'(st_reg[11].sy);

        sum = (F+27)'(st_reg[12].p[0]) + (F+27)'(st_reg[12].p[1]) + (F+27)'(HALF);
        v = 25'(sum >> F);
        r = (v + 25'd128) >> 8;
        noise_next = (r > 25'd65535) ? 16'hffff : r[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[NS-1:1], in_vld};
            done_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= NS; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        noise_reg <= noise_next;
    end

    assign done  = done_reg;
    assign noise = noise_reg;
endmodule

@@ sv/hashed_value_noise_2d.sv @@
// hashed 2d value noise, one position per clock while busy is low. an item
// is taken when start is high and busy is low; its noise value shows on
// noise with done high for one cycle. the output cannot be held off, so
// read it the cycle done is high. an item passes the front scale multiplier,
// the queue and the 13 stages of the back pipeline (six fnv folds, two
// finalizer multiplies, value map and two blend steps of two stages each).
// busy only rises if the queue backs up. cfg writes (inv_wavelength) are
// always ready and should be made while idle.
module hashed_value_noise_2d #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] x_pos,
    input  logic signed [30:0] y_pos,
    input  logic [31:0]        salt,
    output logic               done,
    output logic [15:0]        noise
);
    import hvn_pkg::*;

    logic    accept;
    logic    push;
    q_item_t push_item;
    q_item_t head;
    q_stat_t stat;

    assign busy   = stat.afull;
    assign accept = start && !busy;

    hvn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .salt      (salt),
        .push      (push),
        .push_item (push_item)
    );

    hvn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (1'b1),
        .head      (head),
        .stat      (stat)
    );

    hvn_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (!stat.empty),
        .in_item (head),
        .done    (done),
        .noise   (noise)
    );
endmodule

@@ sv/hvn_checker.sv @@
module hvn_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_ready
);
    localparam int LAT = 15;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("missing result beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result beat without an accepted item");

    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("queue backed up with a free-running back end");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg channel not ready");
endmodule

bind hashed_value_noise_2d hvn_checker u_hvn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
);
